>>> sv/escape_time_fractal_pixel_defines.svh
// Assertion macros for the escape-time fractal pixel block.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_DEFINES_SVH
`ifndef ASSERT_OFF
`define EFP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");
`define EFP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`else
`define EFP_ASSERT(lbl, prop)
`define EFP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> sv/efp_pkg.sv
// Shared types, constants and the saturating function of the escape-time fractal pixel block.
package efp_pkg;

	localparam int MAX_ITER = 100;
	localparam int ITER_W = $clog2(MAX_ITER + 1);

	localparam logic [31:0] MANDEL_MULT = 32'h0010_0506;
	localparam logic [31:0] JULIA_MULT = 32'h0000_0404;
	localparam logic [63:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

	typedef enum logic [2:0] {
		CFG_MODE = 3'd0,
		CFG_CENTER_X = 3'd1,
		CFG_CENTER_Y = 3'd2,
		CFG_PIXEL_STEP = 3'd3,
		CFG_JULIA_RE = 3'd4,
		CFG_JULIA_IM = 3'd5,
		CFG_COLOR_OFFSET = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic mode;
		logic [11:0] center_x;
		logic [11:0] center_y;
		logic [30:0] pixel_step;
		logic signed [31:0] julia_re;
		logic signed [31:0] julia_im;
		logic signed [10:0] color_offset;
	} cfg_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} pix_t;

	typedef struct packed {
		logic [31:0] color;
		logic [6:0] iterations;
		logic escaped;
	} res_t;

	typedef struct packed {
		logic signed [31:0] zr;
		logic signed [31:0] zi;
		logic signed [31:0] cr;
		logic signed [31:0] ci;
		logic [ITER_W-1:0] iter;
		logic done;
	} z_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> sv/escape_time_fractal_pixel.sv
// Top level of the escape-time fractal pixel pipeline.
// Usage:
//   pix / pix_valid / pix_stall carry one pixel coordinate word in; res / res_valid /
//   res_stall carry one color word out per pixel, in input order.
//   cfg_we, cfg_index, cfg_data write the mode, center, step, Julia constant and color
//   offset registers; write them only while the pipeline is empty.
// Pipeline: the pixel map (product, then saturate and start value), then per unrolled
//   iteration a product stage and a sum and escape test stage, then the color stages.
// Throughput: one pixel per cycle unless stalled; each iteration has its own multipliers.
// Reset: all valid bits clear, configuration registers take their reset values.
// Stall: while res_valid is high and res_stall is high the whole pipeline holds
//   and pix_stall is raised; nothing is dropped or repeated.
`include "escape_time_fractal_pixel_defines.svh"
module escape_time_fractal_pixel (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	output logic pix_stall,
	input efp_pkg::pix_t pix,
	output logic res_valid,
	input logic res_stall,
	output efp_pkg::res_t res,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);

	efp_pkg::cfg_t cfg_q;
	logic en;
	logic chain_v [efp_pkg::MAX_ITER+1];
	efp_pkg::z_t chain_w [efp_pkg::MAX_ITER+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= 1'b0;
			cfg_q.center_x <= 12'd980;
			cfg_q.center_y <= 12'd540;
			cfg_q.pixel_step <= 31'd536871;
			cfg_q.julia_re <= 32'sd76503654;
			cfg_q.julia_im <= 32'sd2684355;
			cfg_q.color_offset <= 11'sd1;
		end else if (cfg_we) begin
			unique case (efp_pkg::cfg_idx_t'(cfg_index))
				efp_pkg::CFG_MODE: cfg_q.mode <= cfg_data[0];
				efp_pkg::CFG_CENTER_X: cfg_q.center_x <= cfg_data[11:0];
				efp_pkg::CFG_CENTER_Y: cfg_q.center_y <= cfg_data[11:0];
				efp_pkg::CFG_PIXEL_STEP: cfg_q.pixel_step <= cfg_data[30:0];
				efp_pkg::CFG_JULIA_RE: cfg_q.julia_re <= cfg_data;
				efp_pkg::CFG_JULIA_IM: cfg_q.julia_im <= cfg_data;
				efp_pkg::CFG_COLOR_OFFSET: cfg_q.color_offset <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign en = !(res_valid && res_stall);
	assign pix_stall = !en;

	efp_map u_map (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.cfg(cfg_q),
		.in_valid(pix_valid),
		.in_word(pix),
		.out_valid(chain_v[0]),
		.out_word(chain_w[0])
	);

	for (genvar i = 0; i < efp_pkg::MAX_ITER; i++) begin : g_iter
		efp_iter u_iter (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(chain_v[i]),
			.in_word(chain_w[i]),
			.out_valid(chain_v[i+1]),
			.out_word(chain_w[i+1])
		);
	end

	efp_color u_color (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.cfg(cfg_q),
		.in_valid(chain_v[efp_pkg::MAX_ITER]),
		.in_word(chain_w[efp_pkg::MAX_ITER]),
		.out_valid(res_valid),
		.out_word(res)
	);

	`EFP_ASSERT_IMPL(a_limit_black, res_valid && !res.escaped, res.color == 32'd0)
	`EFP_ASSERT_IMPL(a_limit_count, res_valid && !res.escaped,
		res.iterations == 7'(efp_pkg::MAX_ITER))
	`EFP_ASSERT_IMPL(a_done_count, chain_v[efp_pkg::MAX_ITER] && !chain_w[efp_pkg::MAX_ITER].done,
		chain_w[efp_pkg::MAX_ITER].iter == efp_pkg::ITER_W'(efp_pkg::MAX_ITER))

endmodule

>>> sv/efp_map.sv
// Pixel to complex point mapping and start value selection.
module efp_map (
	input logic clk,
	input logic arst_n,
	input logic en,
	input efp_pkg::cfg_t cfg,
	input logic in_valid,
	input efp_pkg::pix_t in_word,
	output logic out_valid,
	output efp_pkg::z_t out_word
);

	logic signed [12:0] dx;
	logic signed [12:0] dy;
	logic signed [44:0] px_c;
	logic signed [44:0] py_c;
	logic v_s1;
	logic signed [44:0] px_s1;
	logic signed [44:0] py_s1;
	logic signed [31:0] pr;
	logic signed [31:0] pi;
	efp_pkg::z_t w_next;
	logic v_s2;
	efp_pkg::z_t w_s2;

	assign dx = $signed({1'b0, in_word.pixel_x}) - $signed({1'b0, cfg.center_x});
	assign dy = $signed({1'b0, in_word.pixel_y}) - $signed({1'b0, cfg.center_y});
	assign px_c = 45'(dx) * $signed({1'b0, cfg.pixel_step});
	assign py_c = 45'(dy) * $signed({1'b0, cfg.pixel_step});

	assign pr = efp_pkg::sat32(64'(px_s1));
	assign pi = efp_pkg::sat32(64'(py_s1));

	always_comb begin
		w_next = '0;
		if (cfg.mode) begin
			w_next.zr = pr;
			w_next.zi = pi;
			w_next.cr = cfg.julia_re;
			w_next.ci = cfg.julia_im;
		end else begin
			w_next.cr = pr;
			w_next.ci = pi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px_c;
			py_s1 <= py_c;
			w_s2 <= w_next;
		end
	end

	assign out_valid = v_s2;
	assign out_word = w_s2;

endmodule

>>> sv/efp_iter.sv
// One iteration of z = z^2 + c: product stage, then sum, saturate and escape test.
module efp_iter (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input efp_pkg::z_t in_word,
	output logic out_valid,
	output efp_pkg::z_t out_word
);

	logic v_s1;
	efp_pkg::z_t w_s1;
	logic signed [63:0] xx_s1;
	logic signed [63:0] yy_s1;
	logic signed [63:0] xy_s1;
	logic [63:0] mag;
	logic esc;
	logic signed [63:0] diff;
	logic signed [31:0] nr;
	logic signed [31:0] ni;
	efp_pkg::z_t w_next;
	logic v_s2;
	efp_pkg::z_t w_s2;

	assign mag = xx_s1 + yy_s1;
	assign esc = mag >= efp_pkg::ESC_LIMIT;
	assign diff = xx_s1 - yy_s1;
	assign nr = efp_pkg::sat32((diff >>> 28) + 64'(w_s1.cr));
	assign ni = efp_pkg::sat32((xy_s1 >>> 27) + 64'(w_s1.ci));

	always_comb begin
		w_next = w_s1;
		if (!w_s1.done) begin
			if (esc) begin
				w_next.done = 1'b1;
			end else begin
				w_next.zr = nr;
				w_next.zi = ni;
				w_next.iter = efp_pkg::ITER_W'(w_s1.iter + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= in_word;
			xx_s1 <= 64'(in_word.zr) * 64'(in_word.zr);
			yy_s1 <= 64'(in_word.zi) * 64'(in_word.zi);
			xy_s1 <= 64'(in_word.zr) * 64'(in_word.zi);
			w_s2 <= w_next;
		end
	end

	assign out_valid = v_s2;
	assign out_word = w_s2;

endmodule

>>> sv/efp_color.sv
// Color word from the final real part and the escape flag.
module efp_color (
	input logic clk,
	input logic arst_n,
	input logic en,
	input efp_pkg::cfg_t cfg,
	input logic in_valid,
	input efp_pkg::z_t in_word,
	output logic out_valid,
	output efp_pkg::res_t out_word
);

	logic signed [35:0] zr10;
	logic signed [31:0] k_c;
	logic v_s1;
	logic signed [31:0] k_s1;
	logic [31:0] mult_s1;
	logic [efp_pkg::ITER_W-1:0] iter_s1;
	logic esc_s1;
	logic [31:0] prod;
	logic v_s2;
	efp_pkg::res_t r_s2;

	assign zr10 = 36'(in_word.zr) * 36'sd10;

	always_comb begin
		if (cfg.mode) begin
			k_c = 32'(zr10 >>> 28) + 32'(cfg.color_offset);
		end else begin
			k_c = 32'(in_word.zr >>> 28) + 32'(cfg.color_offset);
		end
	end

	assign prod = 32'(k_s1 * $signed(mult_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1 <= k_c;
			mult_s1 <= cfg.mode ? efp_pkg::JULIA_MULT : efp_pkg::MANDEL_MULT;
			iter_s1 <= in_word.iter;
			esc_s1 <= in_word.done;
			r_s2.color <= esc_s1 ? prod : 32'd0;
			r_s2.iterations <= 7'(iter_s1);
			r_s2.escaped <= esc_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_word = r_s2;

endmodule

>>> verif/escape_time_fractal_pixel_tb.sv
// Self-checking testbench of the escape-time fractal pixel block: random and directed pixels.
`timescale 1ns / 1ps
module escape_time_fractal_pixel_tb;

	localparam int LATENCY = 2 + 2 * efp_pkg::MAX_ITER + 2;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	efp_pkg::pix_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	efp_pkg::res_t res;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	escape_time_fractal_pixel u_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the block's registers
	logic m_mode;
	logic [11:0] m_cx, m_cy;
	logic [30:0] m_step;
	logic signed [31:0] m_jre, m_jim;
	logic signed [10:0] m_off;

	efp_pkg::res_t color_queue[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_escaped = 0;
	int n_julia = 0;
	longint cycles = 0;
	int stall_mode = 0;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint map_coord(input logic [11:0] p, input logic [11:0] c);
		longint d;
		d = longint'({1'b0, p}) - longint'({1'b0, c});
		return clamp32(d * longint'({1'b0, m_step}));
	endfunction

	function automatic efp_pkg::res_t predict_color(input efp_pkg::pix_t p);
		efp_pkg::res_t r;
		longint pr, pi, zr, zi, cr, ci, xx, yy, nr, ni, k;
		logic [63:0] mag;
		int it;
		pr = map_coord(p.pixel_x, m_cx);
		pi = map_coord(p.pixel_y, m_cy);
		if (m_mode) begin
			zr = pr; zi = pi; cr = m_jre; ci = m_jim;
		end else begin
			zr = 0; zi = 0; cr = pr; ci = pi;
		end
		it = 0;
		while (it < efp_pkg::MAX_ITER) begin
			xx = zr * zr;
			yy = zi * zi;
			mag = 64'(xx) + 64'(yy);
			if (mag >= efp_pkg::ESC_LIMIT) break;
			nr = clamp32(((xx - yy) >>> 28) + cr);
			ni = clamp32(((zr * zi) >>> 27) + ci);
			zr = nr;
			zi = ni;
			it++;
		end
		r = '0;
		if (it < efp_pkg::MAX_ITER) begin
			if (m_mode) r.color = 32'(((zr * 10) >>> 28) + longint'(m_off))
				* efp_pkg::JULIA_MULT;
			else r.color = 32'((zr >>> 28) + longint'(m_off)) * efp_pkg::MANDEL_MULT;
		end
		r.iterations = 7'(it);
		r.escaped = (it < efp_pkg::MAX_ITER);
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stall pattern and result check
	always @(posedge clk) begin
		efp_pkg::res_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			n_checked <= n_checked + 1;
			if (color_queue.size() == 0) begin
				$display("%0t unexpected word: got %h", $time, res);
				errors++;
			end else begin
				exp_r = color_queue.pop_front();
				if (res.color !== exp_r.color)
					$display("%0t color: expected %h actual %h", $time, exp_r.color, res.color);
				if (res.iterations !== exp_r.iterations)
					$display("%0t iterations: expected %0d actual %0d", $time,
						exp_r.iterations, res.iterations);
				if (res.escaped !== exp_r.escaped)
					$display("%0t escaped: expected %b actual %b", $time,
						exp_r.escaped, res.escaped);
				if (res !== exp_r) errors++;
				if (exp_r.escaped) n_escaped <= n_escaped + 1;
			end
		end
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			default: res_stall <= ($urandom_range(0, 9) < 6);
		endcase
	end

	task automatic write_reg(input efp_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			efp_pkg::CFG_MODE: m_mode = val[0];
			efp_pkg::CFG_CENTER_X: m_cx = val[11:0];
			efp_pkg::CFG_CENTER_Y: m_cy = val[11:0];
			efp_pkg::CFG_PIXEL_STEP: m_step = val[30:0];
			efp_pkg::CFG_JULIA_RE: m_jre = val;
			efp_pkg::CFG_JULIA_IM: m_jim = val;
			efp_pkg::CFG_COLOR_OFFSET: m_off = val[10:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		while (color_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
		efp_pkg::pix_t p;
		p.pixel_x = x;
		p.pixel_y = y;
		pix_valid <= 1'b1;
		pix <= p;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		color_queue.push_back(predict_color(p));
		n_sent++;
		if (m_mode) n_julia++;
	endtask

	task automatic send_bursts(input int count, input logic [11:0] cx, input int spread);
		int burst;
		int left;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if ($urandom_range(0, 7) == 0) burst = 0;
			while (burst > 0 && left > 0) begin
				if ($urandom_range(0, 9) == 0)
					send_pixel(12'($urandom), 12'($urandom));
				else
					send_pixel(12'(int'(cx) + $urandom_range(0, 2 * spread) - spread),
						12'(int'(m_cy) + $urandom_range(0, 2 * spread) - spread));
				burst--;
				left--;
			end
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic test_reset_values();
		stall_mode = 0;
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd980, 12'd540);
		send_pixel(12'd500, 12'd540);
		send_pixel(12'd1100, 12'd600);
		drain();
	endtask

	task automatic test_extremes();
		stall_mode = 1;
		write_reg(efp_pkg::CFG_PIXEL_STEP, 32'd0);
		send_pixel(12'd0, 12'd4095);
		drain();
		write_reg(efp_pkg::CFG_PIXEL_STEP, 32'h7fff_ffff);
		write_reg(efp_pkg::CFG_CENTER_X, 32'd0);
		write_reg(efp_pkg::CFG_CENTER_Y, 32'd4095);
		write_reg(efp_pkg::CFG_COLOR_OFFSET, 32'h0000_0400);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd0, 12'd0);
		drain();
		write_reg(efp_pkg::CFG_MODE, 32'd1);
		write_reg(efp_pkg::CFG_JULIA_RE, 32'h8000_0000);
		write_reg(efp_pkg::CFG_JULIA_IM, 32'h7fff_ffff);
		write_reg(efp_pkg::CFG_COLOR_OFFSET, 32'h0000_03ff);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		drain();
		write_reg(efp_pkg::CFG_JULIA_RE, 32'h0);
		write_reg(efp_pkg::CFG_JULIA_IM, 32'h0);
		write_reg(efp_pkg::CFG_CENTER_X, 32'd2048);
		write_reg(efp_pkg::CFG_CENTER_Y, 32'd2048);
		write_reg(efp_pkg::CFG_PIXEL_STEP, 32'd1 << 24);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd2064, 12'd2048);
		send_pixel(12'd2080, 12'd2048);
		send_pixel(12'd2016, 12'd2060);
		drain();
	endtask

	task automatic test_random_mandelbrot();
		write_reg(efp_pkg::CFG_MODE, 32'd0);
		write_reg(efp_pkg::CFG_CENTER_X, 32'd980);
		write_reg(efp_pkg::CFG_CENTER_Y, 32'd540);
		write_reg(efp_pkg::CFG_PIXEL_STEP, 32'd536871);
		write_reg(efp_pkg::CFG_COLOR_OFFSET, 32'd1);
		stall_mode = 1;
		send_bursts(400, 12'd980, 500);
		drain();
		write_reg(efp_pkg::CFG_PIXEL_STEP, 32'd1 << 20);
		write_reg(efp_pkg::CFG_COLOR_OFFSET, $urandom);
		stall_mode = 2;
		send_bursts(400, 12'd980, 600);
		drain();
	endtask

	task automatic test_random_julia();
		write_reg(efp_pkg::CFG_MODE, 32'd1);
		write_reg(efp_pkg::CFG_JULIA_RE, 32'd76503654);
		write_reg(efp_pkg::CFG_JULIA_IM, 32'd2684355);
		write_reg(efp_pkg::CFG_PIXEL_STEP, 32'd536871 * 2);
		stall_mode = 0;
		send_bursts(400, 12'd980, 600);
		drain();
		write_reg(efp_pkg::CFG_JULIA_RE, 32'hF3FF_FFFF - $urandom_range(0, 1 << 26));
		write_reg(efp_pkg::CFG_JULIA_IM, 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26)));
		write_reg(efp_pkg::CFG_COLOR_OFFSET, 32'hFFFF_FC00);
		stall_mode = 1;
		send_bursts(400, 12'd980, 700);
		drain();
	endtask

	task automatic test_random_settings();
		int k;
		for (k = 0; k < 4; k++) begin
			write_reg(efp_pkg::CFG_MODE, $urandom);
			write_reg(efp_pkg::CFG_CENTER_X, $urandom);
			write_reg(efp_pkg::CFG_CENTER_Y, $urandom);
			write_reg(efp_pkg::CFG_PIXEL_STEP, $urandom_range(1, 1 << 22));
			write_reg(efp_pkg::CFG_JULIA_RE, 32'(int'($urandom_range(0, 1 << 29)) - (1 << 28)));
			write_reg(efp_pkg::CFG_JULIA_IM, 32'(int'($urandom_range(0, 1 << 29)) - (1 << 28)));
			write_reg(efp_pkg::CFG_COLOR_OFFSET, $urandom);
			stall_mode = k % 3;
			send_bursts(100, m_cx, 400);
			drain();
		end
	endtask

	initial begin
		m_mode = 1'b0;
		m_cx = 12'd980;
		m_cy = 12'd540;
		m_step = 31'd536871;
		m_jre = 32'sd76503654;
		m_jim = 32'sd2684355;
		m_off = 11'sd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_values();
		test_extremes();
		test_random_mandelbrot();
		test_random_julia();
		test_random_settings();
		$display("Sent %0d pixels (%0d Julia), checked %0d words, %0d escaped.",
			n_sent, n_julia, n_checked, n_escaped);
		if (errors == 0 && color_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
